// ===== rtl/csvt_pkg.sv =====
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int SPACE_DEPTH_DEF = 32;

  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] LF_CH    = 8'h0A;
  localparam logic [7:0] CR_CH    = 8'h0D;

  localparam logic [20:0] RAW_SAT = 21'h1F_FFFF;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 26;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FIELD      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FIELDS_ROW = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROWS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INPUT      = 3'd4;

  localparam logic [7:0]  DELIMITER_RST      = 8'd44;
  localparam logic [20:0] MAX_FIELD_RST      = 21'(1024 * 1024);
  localparam logic [12:0] MAX_FIELDS_ROW_RST = 13'd512;
  localparam logic [19:0] MAX_ROWS_RST       = 20'd100000;
  localparam logic [25:0] MAX_INPUT_RST      = 26'(25 * 1024 * 1024);

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_ROW_END   = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_DONE      = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_INPUT_LONG = 3'd0,
    ERR_FIELD_LONG = 3'd1,
    ERR_FIELDS     = 3'd2,
    ERR_ROWS       = 3'd3,
    ERR_QUOTE      = 3'd4,
    ERR_SPACE      = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    err_t       error_code;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd_first;
    logic flush_load;
    logic emit_load;
    logic wr_late;
  } ctrl_cmd_t;

  typedef struct packed {
    logic step_results;
    logic step_flush;
    logic slot_free;
    logic flush_last;
    logic emit_last;
  } dp_status_t;

endpackage

// ===== rtl/csv_field_tokenizer_unit.sv =====
`timescale 1ns / 1ps

// Streaming CSV tokenizer: takes one text byte per request and returns the unescaped,
// trimmed field bytes followed by field-end and row-end markers, a done marker after
// the byte flagged end_of_text, or a single error result after which the block ignores
// input until reset (the consumer should drop what it got of that stream). Each result
// carries last_of_run on the final result of its input byte. A byte that yields no
// result, or one result, leaves the input open, so plain text streams at one byte per
// cycle while out_stall is low; a byte with more results sends them in turn through
// the single output register. When a non-space byte ends a run of buffered trailing
// spaces, they are replayed from the space buffer RAM at one byte per cycle while
// out_stall is low, after a registered read of entry zero. Write configuration
// registers only while the block is idle; no clearing pass is needed after reset.
module csv_field_tokenizer_unit #(
  parameter int SPACE_DEPTH = csvt_pkg::SPACE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  csvt_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output csvt_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [csvt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [csvt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  csvt_pkg::ctrl_cmd_t  cmd;
  csvt_pkg::dp_status_t status;

  csvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  csvt_dpath #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ===== rtl/csvt_ram.sv =====
`timescale 1ns / 1ps

module csvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/csvt_ctrl.sv =====
`timescale 1ns / 1ps

module csvt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  csvt_pkg::dp_status_t   status,
  output csvt_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_PRE: begin
        // read of entry zero in flight
        cmd.rd_first = 1'b1;
        state_nxt    = S_FLUSH;
      end
      S_FLUSH: begin
        if (status.slot_free) begin
          cmd.flush_load = 1'b1;
          if (status.flush_last) begin
            cmd.wr_late = 1'b1;
            state_nxt   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_load = 1'b1;
          // last result goes out: take the next request in the same cycle
          if (status.emit_last) begin
            in_stall   = 1'b0;
            cmd.accept = in_valid;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.accept && status.step_results) begin
      state_nxt = status.step_flush ? S_PRE : S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/csvt_dpath.sv =====
`timescale 1ns / 1ps

module csvt_dpath #(
  parameter int SPACE_DEPTH = csvt_pkg::SPACE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [csvt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [csvt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  csvt_pkg::in_item_t                  in_data,
  input  csvt_pkg::ctrl_cmd_t                 cmd,
  output csvt_pkg::dp_status_t                status,
  output logic                                out_valid,
  output csvt_pkg::out_item_t                 out_data,
  input  logic                                out_stall
);

  localparam int AW  = $clog2(SPACE_DEPTH);
  localparam int SCW = $clog2(SPACE_DEPTH + 1);

  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_FIELD,
    MARK_ROW
  } mark_t;

  typedef struct packed {
    logic             err;
    csvt_pkg::err_t   code;
    logic [20:0]      raw;
    logic             has;
    logic [SCW-1:0]   sc;
    logic             put;
    logic [SCW-1:0]   flush;
    logic             wr;
    logic [AW-1:0]    wa;
  } cont_t;

  typedef struct packed {
    logic             err;
    csvt_pkg::err_t   code;
    logic             kept;
    logic [19:0]      rows;
  } close_t;

  // configuration
  logic [7:0]  delim_r;
  logic [20:0] max_field_r;
  logic [12:0] max_fpr_r;
  logic [19:0] max_rows_r;
  logic [25:0] max_in_r;

  // tokenizer state
  logic           inq_r, qp_r, has_r, halted_r;
  logic [SCW-1:0] sc_r;
  logic [20:0]    raw_r;
  logic [12:0]    fields_r;
  logic [19:0]    rows_r;
  logic [25:0]    bytes_r;

  // results still owed for the current request
  logic           err_r, q_r, b_r, done_r, wr_pend_r;
  mark_t          mark_r;
  csvt_pkg::err_t code_r;
  logic [7:0]     byte_r;
  logic [SCW-1:0] flush_n_r;
  logic [AW-1:0]  idx_r;
  logic [AW-1:0]  wr_addr_r;
  logic [7:0]     wr_data_r;

  logic                out_valid_r;
  csvt_pkg::out_item_t out_r;

  // step outcome
  logic           s_err, s_q, s_b, s_done, s_wr;
  csvt_pkg::err_t s_code;
  mark_t          s_mark;
  logic [SCW-1:0] s_flush;
  logic [AW-1:0]  s_wa;
  logic           n_inq, n_qp, n_has;
  logic [SCW-1:0] n_sc;
  logic [20:0]    n_raw;
  logic [12:0]    n_fields;
  logic [19:0]    n_rows;
  logic [25:0]    n_bytes;

  logic [7:0] b;
  logic       eot;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  csvt_pkg::out_item_t emit_item;
  logic                emit_rest;

  assign b   = in_data.in_byte;
  assign eot = in_data.end_of_text;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic cont_t content(input logic [7:0] c, input logic [20:0] raw,
                                    input logic has, input logic [SCW-1:0] sc,
                                    input logic [20:0] maxf);
    cont_t r;
    r      = '0;
    r.code = csvt_pkg::ERR_FIELD_LONG;
    r.has  = has;
    r.sc   = sc;
    r.raw  = (raw < csvt_pkg::RAW_SAT) ? raw + 21'd1 : raw;
    if (r.raw > maxf) begin
      r.err = 1'b1;
    end else if (is_ws(c)) begin
      // leading space is dropped, trailing space waits in the buffer
      if (has) begin
        if (sc >= SCW'(SPACE_DEPTH)) begin
          r.err  = 1'b1;
          r.code = csvt_pkg::ERR_SPACE;
        end else begin
          r.wr = 1'b1;
          r.wa = sc[AW-1:0];
          r.sc = sc + SCW'(1);
        end
      end
    end else begin
      r.put   = 1'b1;
      r.flush = sc;
      r.sc    = '0;
      r.has   = 1'b1;
    end
    return r;
  endfunction

  function automatic close_t close_row(input logic [12:0] fields, input logic has,
                                       input logic [19:0] rows, input logic [12:0] maxfpr,
                                       input logic [19:0] maxrows);
    close_t r;
    r      = '0;
    r.code = csvt_pkg::ERR_FIELDS;
    r.rows = rows;
    if ({1'b0, fields} + 14'd1 > {1'b0, maxfpr}) begin
      r.err = 1'b1;
    end else if (fields != 13'd0 || has) begin
      if (rows >= maxrows) begin
        r.err  = 1'b1;
        r.code = csvt_pkg::ERR_ROWS;
      end else begin
        r.kept = 1'b1;
        r.rows = rows + 20'd1;
      end
    end
    return r;
  endfunction

  always_comb begin
    cont_t       c;
    close_t      k;
    logic        unq;
    logic [26:0] nb;
    c        = '0;
    k        = '0;
    unq      = 1'b0;
    nb       = {1'b0, bytes_r} + 27'd1;
    s_err    = 1'b0;
    s_code   = csvt_pkg::ERR_INPUT_LONG;
    s_q      = 1'b0;
    s_b      = 1'b0;
    s_done   = 1'b0;
    s_mark   = MARK_NONE;
    s_flush  = '0;
    s_wr     = 1'b0;
    s_wa     = '0;
    n_inq    = inq_r;
    n_qp     = qp_r;
    n_has    = has_r;
    n_sc     = sc_r;
    n_raw    = raw_r;
    n_fields = fields_r;
    n_rows   = rows_r;
    n_bytes  = bytes_r;

    if (nb > {1'b0, max_in_r}) begin
      s_err = 1'b1;
    end else begin
      n_bytes = nb[25:0];
      if (qp_r) begin
        n_qp = 1'b0;
        if (b == csvt_pkg::QUOTE_CH) begin
          // doubled quote: one literal quote
          c = content(csvt_pkg::QUOTE_CH, raw_r, has_r, sc_r, max_field_r);
          if (c.err) begin
            s_err  = 1'b1;
            s_code = c.code;
          end else begin
            n_raw   = c.raw;
            n_has   = c.has;
            n_sc    = c.sc;
            s_q     = 1'b1;
            s_flush = c.flush;
          end
        end else if (b == delim_r || b == csvt_pkg::CR_CH || b == csvt_pkg::LF_CH) begin
          n_inq = 1'b0;
          unq   = 1'b1;
        end else begin
          // stray quote: keep it and the byte after it
          c = content(csvt_pkg::QUOTE_CH, raw_r, has_r, sc_r, max_field_r);
          if (c.err) begin
            s_err  = 1'b1;
            s_code = c.code;
          end else begin
            s_q     = 1'b1;
            s_flush = c.flush;
            c = content(b, c.raw, c.has, c.sc, max_field_r);
            if (c.err) begin
              s_err  = 1'b1;
              s_code = c.code;
            end else begin
              n_raw = c.raw;
              n_has = c.has;
              n_sc  = c.sc;
              s_b   = c.put;
              s_wr  = c.wr;
              s_wa  = c.wa;
            end
          end
        end
      end else if (inq_r) begin
        if (b == csvt_pkg::QUOTE_CH) begin
          if (eot) begin
            n_inq = 1'b0;
          end else begin
            n_qp = 1'b1;
          end
        end else begin
          c = content(b, raw_r, has_r, sc_r, max_field_r);
          if (c.err) begin
            s_err  = 1'b1;
            s_code = c.code;
          end else begin
            n_raw   = c.raw;
            n_has   = c.has;
            n_sc    = c.sc;
            s_b     = c.put;
            s_flush = c.flush;
            s_wr    = c.wr;
            s_wa    = c.wa;
          end
        end
      end else begin
        unq = 1'b1;
      end

      if (unq) begin
        if (b == csvt_pkg::QUOTE_CH) begin
          n_inq = 1'b1;
        end else if (b == delim_r) begin
          if ({1'b0, fields_r} + 14'd1 > {1'b0, max_fpr_r}) begin
            s_err  = 1'b1;
            s_code = csvt_pkg::ERR_FIELDS;
          end else begin
            n_fields = fields_r + 13'd1;
            n_has    = 1'b0;
            n_sc     = '0;
            n_raw    = '0;
            s_mark   = MARK_FIELD;
          end
        end else if (b == csvt_pkg::LF_CH) begin
          k = close_row(fields_r, has_r, rows_r, max_fpr_r, max_rows_r);
          if (k.err) begin
            s_err  = 1'b1;
            s_code = k.code;
          end else begin
            n_rows   = k.rows;
            n_fields = '0;
            n_has    = 1'b0;
            n_sc     = '0;
            n_raw    = '0;
            s_mark   = k.kept ? MARK_ROW : MARK_NONE;
          end
        end else if (b != csvt_pkg::CR_CH) begin
          c = content(b, raw_r, has_r, sc_r, max_field_r);
          if (c.err) begin
            s_err  = 1'b1;
            s_code = c.code;
          end else begin
            n_raw   = c.raw;
            n_has   = c.has;
            n_sc    = c.sc;
            s_b     = c.put;
            s_flush = c.flush;
            s_wr    = c.wr;
            s_wa    = c.wa;
          end
        end
      end

      if (!s_err && eot) begin
        if (n_inq) begin
          s_err  = 1'b1;
          s_code = csvt_pkg::ERR_QUOTE;
        end else begin
          k = close_row(n_fields, n_has, n_rows, max_fpr_r, max_rows_r);
          if (k.err) begin
            s_err  = 1'b1;
            s_code = k.code;
          end else begin
            n_rows   = k.rows;
            n_fields = '0;
            n_has    = 1'b0;
            n_sc     = '0;
            n_raw    = '0;
            s_done   = 1'b1;
          end
        end
      end
    end
  end

  // pick the next owed result: error, quote, byte, marker, done
  always_comb begin
    emit_item            = '0;
    emit_item.kind       = csvt_pkg::KIND_DONE;
    emit_item.error_code = csvt_pkg::ERR_INPUT_LONG;
    emit_rest            = 1'b0;
    if (err_r) begin
      emit_item.kind       = csvt_pkg::KIND_ERROR;
      emit_item.error_code = code_r;
    end else if (q_r) begin
      emit_item.kind     = csvt_pkg::KIND_BYTE;
      emit_item.out_byte = csvt_pkg::QUOTE_CH;
      emit_rest          = b_r || (mark_r != MARK_NONE) || done_r;
    end else if (b_r) begin
      emit_item.kind     = csvt_pkg::KIND_BYTE;
      emit_item.out_byte = byte_r;
      emit_rest          = (mark_r != MARK_NONE) || done_r;
    end else if (mark_r != MARK_NONE) begin
      emit_item.kind = (mark_r == MARK_FIELD) ? csvt_pkg::KIND_FIELD_END :
                                                csvt_pkg::KIND_ROW_END;
      emit_rest      = done_r;
    end
    emit_item.last_of_run = !emit_rest;
  end

  assign status.step_results = !halted_r && (s_err || s_q || s_b || s_done ||
                                             (s_mark != MARK_NONE));
  assign status.step_flush   = !halted_r && !s_err && (s_flush != '0);
  assign status.slot_free    = !out_valid_r || !out_stall;
  assign status.flush_last   = (SCW'(idx_r) + SCW'(1)) == flush_n_r;
  assign status.emit_last    = !emit_rest;

  // a buffered space behind a flush is written with the flush's last load, after entry zero is read
  assign ram_we    = (cmd.accept && !halted_r && !s_err && s_wr && (s_flush == '0)) ||
                     (cmd.wr_late && wr_pend_r);
  assign ram_waddr = cmd.wr_late ? wr_addr_r : s_wa;
  assign ram_wdata = cmd.wr_late ? wr_data_r : b;
  assign ram_raddr = cmd.rd_first   ? '0 :
                     cmd.flush_load ? idx_r + AW'(1) : idx_r;

  csvt_ram #(
    .WIDTH (8),
    .DEPTH (SPACE_DEPTH)
  ) u_space_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= csvt_pkg::DELIMITER_RST;
      max_field_r <= csvt_pkg::MAX_FIELD_RST;
      max_fpr_r   <= csvt_pkg::MAX_FIELDS_ROW_RST;
      max_rows_r  <= csvt_pkg::MAX_ROWS_RST;
      max_in_r    <= csvt_pkg::MAX_INPUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csvt_pkg::REG_DELIMITER:      delim_r     <= cfg_data[7:0];
        csvt_pkg::REG_MAX_FIELD:      max_field_r <= cfg_data[20:0];
        csvt_pkg::REG_MAX_FIELDS_ROW: max_fpr_r   <= cfg_data[12:0];
        csvt_pkg::REG_MAX_ROWS:       max_rows_r  <= cfg_data[19:0];
        csvt_pkg::REG_MAX_INPUT:      max_in_r    <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r    <= 1'b0;
      qp_r     <= 1'b0;
      has_r    <= 1'b0;
      halted_r <= 1'b0;
      sc_r     <= '0;
      raw_r    <= '0;
      fields_r <= '0;
      rows_r   <= '0;
      bytes_r  <= '0;
    end else if (cmd.accept && !halted_r) begin
      inq_r    <= n_inq;
      qp_r     <= n_qp;
      has_r    <= n_has;
      halted_r <= s_err || eot;
      sc_r     <= n_sc;
      raw_r    <= n_raw;
      fields_r <= n_fields;
      rows_r   <= n_rows;
      bytes_r  <= n_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r     <= 1'b0;
      q_r       <= 1'b0;
      b_r       <= 1'b0;
      done_r    <= 1'b0;
      mark_r    <= MARK_NONE;
      wr_pend_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (halted_r) begin
          err_r     <= 1'b0;
          q_r       <= 1'b0;
          b_r       <= 1'b0;
          done_r    <= 1'b0;
          mark_r    <= MARK_NONE;
          wr_pend_r <= 1'b0;
        end else begin
          // an error discards every other result of the request
          err_r     <= s_err;
          q_r       <= !s_err && s_q;
          b_r       <= !s_err && s_b;
          done_r    <= !s_err && s_done;
          mark_r    <= s_err ? MARK_NONE : s_mark;
          wr_pend_r <= !s_err && s_wr && (s_flush != '0);
        end
      end else begin
        if (cmd.emit_load) begin
          if (err_r) begin
            err_r <= 1'b0;
          end else if (q_r) begin
            q_r <= 1'b0;
          end else if (b_r) begin
            b_r <= 1'b0;
          end else if (mark_r != MARK_NONE) begin
            mark_r <= MARK_NONE;
          end else begin
            done_r <= 1'b0;
          end
        end
        if (cmd.wr_late) begin
          wr_pend_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r    <= s_code;
      byte_r    <= b;
      flush_n_r <= s_flush;
      wr_addr_r <= s_wa;
      wr_data_r <= b;
    end
    if (cmd.rd_first) begin
      idx_r <= '0;
    end else if (cmd.flush_load) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.flush_load || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_load) begin
      out_r.kind        <= csvt_pkg::KIND_BYTE;
      out_r.out_byte    <= ram_rdata;
      out_r.error_code  <= csvt_pkg::ERR_INPUT_LONG;
      out_r.last_of_run <= 1'b0;
    end else if (cmd.emit_load) begin
      out_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_csv_field_tokenizer_unit.sv =====
`timescale 1ns / 1ps

module tb_csv_field_tokenizer_unit;

  localparam int SPACE_DEPTH = csvt_pkg::SPACE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DW = csvt_pkg::CFG_DATA_W;
  localparam int IW = csvt_pkg::CFG_INDEX_W;

  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] TAB_CH   = 8'h09;
  localparam logic [7:0] VT_CH    = 8'h0B;
  localparam logic [7:0] FF_CH    = 8'h0C;

  localparam logic [DW-1:0] FIELD_LIM_TOP  = DW'(1048576);
  localparam logic [DW-1:0] FIELDS_LIM_TOP = DW'(4096);
  localparam logic [DW-1:0] ROWS_LIM_TOP   = DW'(1048575);
  localparam logic [DW-1:0] INPUT_LIM_TOP  = DW'(67108863);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  csvt_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  csvt_pkg::out_item_t  out_data;
  logic                 cfg_we = 1'b0;
  logic [IW-1:0]        cfg_index = csvt_pkg::REG_DELIMITER;
  logic [DW-1:0]        cfg_data = '0;

  csv_field_tokenizer_unit #(.SPACE_DEPTH(SPACE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies
  logic [7:0]  sep_cfg    = csvt_pkg::DELIMITER_RST;
  logic [20:0] field_lim  = csvt_pkg::MAX_FIELD_RST;
  logic [12:0] fields_lim = csvt_pkg::MAX_FIELDS_ROW_RST;
  logic [19:0] rows_lim   = csvt_pkg::MAX_ROWS_RST;
  logic [25:0] input_lim  = csvt_pkg::MAX_INPUT_RST;

  // Tokenizer state
  bit          in_quotes = 1'b0;
  bit          quote_held = 1'b0;
  bit          field_started = 1'b0;
  bit          stream_over = 1'b0;
  logic [7:0]  trail_buf[SPACE_DEPTH];
  int unsigned trail_cnt = 0;
  logic [20:0] field_len = '0;
  int unsigned row_fields = 0;
  int unsigned rows_kept = 0;
  int unsigned bytes_seen = 0;

  bit                   step_failed;
  csvt_pkg::out_item_t  step_tokens[$];
  csvt_pkg::out_item_t  expected_tokens[$];
  csvt_pkg::in_item_t   pending_bytes[$];

  int queued_count = 0;
  int result_index = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int in_gap_max = 3;
  int out_gap_max = 3;
  int in_wait = 0;
  int out_hold = 0;
  bit byte_taken = 1'b0;
  bit result_taken = 1'b0;

  function automatic bit is_space(input logic [7:0] b);
    return b == SPACE_CH || (b >= TAB_CH && b <= csvt_pkg::CR_CH);
  endfunction

  function automatic void emit_token(input csvt_pkg::kind_t k, input logic [7:0] b,
                                     input csvt_pkg::err_t e);
    csvt_pkg::out_item_t t;
    t.kind = k;
    t.out_byte = b;
    t.error_code = e;
    t.last_of_run = 1'b0;
    step_tokens = {step_tokens, t};
  endfunction

  // An error replaces everything the byte produced so far
  function automatic void raise_error(input csvt_pkg::err_t e);
    if (step_failed) return;
    step_failed = 1'b1;
    step_tokens.delete();
    emit_token(csvt_pkg::KIND_ERROR, 8'h00, e);
  endfunction

  function automatic void clear_field();
    field_started = 1'b0;
    trail_cnt = 0;
    field_len = '0;
  endfunction

  function automatic bit take_content(input logic [7:0] b);
    int unsigned i;
    if (field_len < csvt_pkg::RAW_SAT) field_len++;
    if (field_len > field_lim) begin
      raise_error(csvt_pkg::ERR_FIELD_LONG);
      return 1'b0;
    end
    if (is_space(b)) begin
      if (!field_started) return 1'b1;
      if (trail_cnt >= SPACE_DEPTH) begin
        raise_error(csvt_pkg::ERR_SPACE);
        return 1'b0;
      end
      trail_buf[trail_cnt] = b;
      trail_cnt++;
      return 1'b1;
    end
    // Buffered whitespace turned out to be inner content
    for (i = 0; i < trail_cnt; i++)
      emit_token(csvt_pkg::KIND_BYTE, trail_buf[i], csvt_pkg::ERR_INPUT_LONG);
    trail_cnt = 0;
    emit_token(csvt_pkg::KIND_BYTE, b, csvt_pkg::ERR_INPUT_LONG);
    field_started = 1'b1;
    return 1'b1;
  endfunction

  // 1: row kept, 0: row dropped as empty, -1: error
  function automatic int close_row_check();
    bit keep;
    if (row_fields + 1 > fields_lim) begin
      raise_error(csvt_pkg::ERR_FIELDS);
      return -1;
    end
    keep = row_fields != 0 || field_started;
    clear_field();
    row_fields = 0;
    if (!keep) return 0;
    if (rows_kept >= rows_lim) begin
      raise_error(csvt_pkg::ERR_ROWS);
      return -1;
    end
    rows_kept++;
    return 1;
  endfunction

  function automatic void handle_unquoted(input logic [7:0] b);
    if (b == csvt_pkg::QUOTE_CH) begin
      in_quotes = 1'b1;
    end else if (b == sep_cfg) begin
      if (row_fields + 1 > fields_lim) begin
        raise_error(csvt_pkg::ERR_FIELDS);
        return;
      end
      row_fields++;
      clear_field();
      emit_token(csvt_pkg::KIND_FIELD_END, 8'h00, csvt_pkg::ERR_INPUT_LONG);
    end else if (b == csvt_pkg::LF_CH) begin
      if (close_row_check() == 1)
        emit_token(csvt_pkg::KIND_ROW_END, 8'h00, csvt_pkg::ERR_INPUT_LONG);
    end else if (b != csvt_pkg::CR_CH) begin
      void'(take_content(b));
    end
  endfunction

  function automatic void tokenize_byte(input csvt_pkg::in_item_t item);
    logic [7:0]  b;
    bit          eot;
    int unsigned nb;
    b = item.in_byte;
    eot = item.end_of_text;
    if (stream_over) return;
    step_failed = 1'b0;
    step_tokens.delete();
    nb = bytes_seen + 1;
    if (nb > input_lim) raise_error(csvt_pkg::ERR_INPUT_LONG);
    else bytes_seen = nb;
    if (!step_failed) begin
      if (quote_held) begin
        quote_held = 1'b0;
        if (b == csvt_pkg::QUOTE_CH) begin
          void'(take_content(csvt_pkg::QUOTE_CH));
        end else if (b == sep_cfg || b == csvt_pkg::CR_CH || b == csvt_pkg::LF_CH) begin
          in_quotes = 1'b0;
          handle_unquoted(b);
        end else if (take_content(csvt_pkg::QUOTE_CH)) begin
          void'(take_content(b));
        end
      end else if (in_quotes) begin
        if (b == csvt_pkg::QUOTE_CH) begin
          if (eot) in_quotes = 1'b0;
          else quote_held = 1'b1;
        end else begin
          void'(take_content(b));
        end
      end else begin
        handle_unquoted(b);
      end
    end
    if (!step_failed && eot) begin
      if (in_quotes) raise_error(csvt_pkg::ERR_QUOTE);
      else if (close_row_check() >= 0)
        emit_token(csvt_pkg::KIND_DONE, 8'h00, csvt_pkg::ERR_INPUT_LONG);
    end
    if (step_failed || eot) stream_over = 1'b1;
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    expected_tokens = {expected_tokens, step_tokens};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // Input side: record the request at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      tokenize_byte(in_data);
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      byte_taken = 1'b0;
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (pending_bytes.size() != 0) begin
        in_data <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side
  always @(posedge clk) begin
    csvt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("result %0d unexpected: kind %0d byte %02h code %0d last %0b",
                                  result_index, out_data.kind, out_data.out_byte,
                                  out_data.error_code, out_data.last_of_run));
      end else begin
        want = expected_tokens.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                    result_index, out_data.kind, want.kind));
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("result %0d byte %02h, want %02h",
                                    result_index, out_data.out_byte, want.out_byte));
        if (out_data.error_code !== want.error_code)
          report_mismatch($sformatf("result %0d error code %0d, want %0d",
                                    result_index, out_data.error_code, want.error_code));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("result %0d last_of_run %0b, want %0b",
                                    result_index, out_data.last_of_run, want.last_of_run));
      end
      result_index++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        out_hold = $urandom_range(0, out_gap_max);
      end
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input bit eot);
    csvt_pkg::in_item_t item;
    item.in_byte = b;
    item.end_of_text = eot;
    pending_bytes = {pending_bytes, item};
    queued_count++;
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == csvt_pkg::QUOTE_CH || b == sep_cfg || b == csvt_pkg::CR_CH ||
               b == csvt_pkg::LF_CH || is_space(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_space(input bit quoted);
    logic [7:0] b;
    do begin
      case ($urandom_range(0, quoted ? 5 : 3))
        0: b = SPACE_CH;
        1: b = TAB_CH;
        2: b = VT_CH;
        3: b = FF_CH;
        4: b = csvt_pkg::CR_CH;
        default: b = csvt_pkg::LF_CH;
      endcase
    end while (b == sep_cfg);
    return b;
  endfunction

  task automatic queue_field();
    int len;
    int k;
    repeat ($urandom_range(0, 2)) queue_byte(pick_space(1'b0), 1'b0);
    len = $urandom_range(1, 8);
    case ($urandom_range(0, 7))
      0: ;
      1, 2, 3, 4: begin
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 15) == 0)
            repeat ($urandom_range(20, SPACE_DEPTH)) queue_byte(SPACE_CH, 1'b0);
          else if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(pick_space(1'b0), 1'b0);
          queue_byte(pick_text_byte(), 1'b0);
        end
        repeat ($urandom_range(0, 2)) queue_byte(pick_space(1'b0), 1'b0);
      end
      5, 6: begin
        queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 5))
            0: begin
              queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
              queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
            end
            1: queue_byte(sep_cfg, 1'b0);
            2: queue_byte(pick_space(1'b1), 1'b0);
            default: queue_byte(pick_text_byte(), 1'b0);
          endcase
        end
        queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
      end
      default: begin
        // stray quote inside a quoted field stays as text
        queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
        queue_byte(pick_text_byte(), 1'b0);
        queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
        queue_byte(pick_text_byte(), 1'b0);
        queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
      end
    endcase
  endtask

  task automatic queue_row();
    int n;
    int f;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      queue_byte(csvt_pkg::LF_CH, 1'b0);
      return;
    end
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(0, 4)) queue_byte(pick_space(1'b0), 1'b0);
      queue_byte(csvt_pkg::LF_CH, 1'b0);
      return;
    end
    n = $urandom_range(1, 6);
    for (f = 0; f < n; f++) begin
      if (f > 0) queue_byte(sep_cfg, 1'b0);
      queue_field();
    end
    if ($urandom_range(0, 3) == 0) queue_byte(csvt_pkg::CR_CH, 1'b0);
    queue_byte(csvt_pkg::LF_CH, 1'b0);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      csvt_pkg::REG_DELIMITER:      sep_cfg = val[7:0];
      csvt_pkg::REG_MAX_FIELD:      field_lim = val[20:0];
      csvt_pkg::REG_MAX_FIELDS_ROW: fields_lim = val[12:0];
      csvt_pkg::REG_MAX_ROWS:       rows_lim = val[19:0];
      csvt_pkg::REG_MAX_INPUT:      input_lim = val[25:0];
      default: ;
    endcase
  endtask

  // Wait for all queued requests and results, then let the block drain
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_tokens.size() != 0);
    repeat (SPACE_DEPTH + 8) @(posedge clk);
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 11;
      default: return $urandom_range(1, 11);
    endcase
  endfunction

  initial begin
    int ph;
    int phase_end;
    int ending;
    bit top;
    logic [7:0] sep;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: byte extremes, quoting, CR drop, trimming, empty row
    queue_byte(8'h00, 1'b0);
    queue_text(" a ,");
    queue_byte(8'hFF, 1'b0);
    queue_text("\r\n");
    queue_text("\"x\"\"y\"z\",\"\"\n");
    queue_text(" \n");

    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      in_gap_max = pick_gap();
      out_gap_max = pick_gap();
      case (ph)
        0: sep = csvt_pkg::DELIMITER_RST;
        1: sep = 8'h00;
        2: sep = 8'hFF;
        3: sep = TAB_CH;
        4: sep = csvt_pkg::QUOTE_CH;
        5: sep = csvt_pkg::CR_CH;
        6: sep = csvt_pkg::LF_CH;
        default: sep = 8'($urandom_range(0, 255));
      endcase
      top = (ph % 2) == 0;
      write_reg(csvt_pkg::REG_DELIMITER, DW'(sep));
      write_reg(csvt_pkg::REG_MAX_FIELD,
                top ? FIELD_LIM_TOP : DW'($urandom_range(4096, 1048576)));
      write_reg(csvt_pkg::REG_MAX_FIELDS_ROW,
                top ? FIELDS_LIM_TOP : DW'($urandom_range(256, 4096)));
      write_reg(csvt_pkg::REG_MAX_ROWS,
                top ? ROWS_LIM_TOP : DW'($urandom_range(1000, 1048575)));
      write_reg(csvt_pkg::REG_MAX_INPUT,
                top ? INPUT_LIM_TOP : DW'($urandom_range(100000, 67108863)));
      // running target keeps the whole stream near its planned length
      phase_end = 24 + (ph + 1) * 26;
      if (ph == 0) begin
        // full whitespace buffer replayed by one byte
        queue_text("a");
        repeat (SPACE_DEPTH) queue_byte(SPACE_CH, 1'b0);
        queue_text("b\n");
      end
      while (queued_count < phase_end) queue_row();
    end

    // Close any open quote and row before the stream ends
    wait_idle();
    if (quote_held) begin
      queue_byte(csvt_pkg::LF_CH, 1'b0);
    end else begin
      if (in_quotes) queue_byte(csvt_pkg::QUOTE_CH, 1'b0);
      queue_byte(csvt_pkg::LF_CH, 1'b0);
    end
    wait_idle();
    in_gap_max = pick_gap();
    out_gap_max = pick_gap();

    ending = $urandom_range(0, 9);
    case (ending)
      0: begin
        queue_text("ab,c");
        queue_byte("d", 1'b1);
      end
      1: begin
        queue_text("x\n");
        queue_byte(SPACE_CH, 1'b1);
      end
      2: begin
        queue_text("k,\"q");
        queue_byte(csvt_pkg::QUOTE_CH, 1'b1);
      end
      3: begin
        queue_text("\"ab");
        queue_byte("c", 1'b1);
      end
      4: begin
        write_reg(csvt_pkg::REG_MAX_FIELD, DW'($urandom_range(0, 3)));
        queue_text("abcdefgh");
      end
      5: begin
        write_reg(csvt_pkg::REG_MAX_FIELDS_ROW, DW'($urandom_range(0, 3)));
        queue_text("a,b,c,d\n");
      end
      6: begin
        write_reg(csvt_pkg::REG_MAX_ROWS, DW'(rows_kept));
        queue_text("z\n");
      end
      7: begin
        write_reg(csvt_pkg::REG_MAX_INPUT, DW'(bytes_seen + $urandom_range(0, 4)));
        queue_text("abcdefgh");
      end
      8: begin
        queue_text("w");
        repeat (SPACE_DEPTH + 8) queue_byte(SPACE_CH, 1'b0);
      end
      default: begin
        // held quote closed by a final LF
        queue_text("\"ab\"");
        queue_byte(csvt_pkg::LF_CH, 1'b1);
      end
    endcase
    wait_idle();

    // Halted: these must produce nothing
    repeat (6) queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_idle();

    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csvt_pkg.sv
rtl/csvt_ram.sv
rtl/csvt_ctrl.sv
rtl/csvt_dpath.sv
rtl/csv_field_tokenizer_unit.sv
tb/tb_csv_field_tokenizer_unit.sv
